### rtl/ppsb_pkg.sv
// ----------------------------------------------------------------------------
// ppsb_pkg
// Shared types and constants for the ping-pong sample buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ppsb_pkg;

  // Default geometry
  localparam int unsigned BANK_DEPTH_DEF   = 1024;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned PADDR_W = 3;

  // Register file
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(1024);
  localparam logic               REG_BANK_LIMIT = 1'b0;

  // Request opcodes
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

### rtl/ping_pong_sample_buffer_unit.sv
// ----------------------------------------------------------------------------
// ping_pong_sample_buffer_unit
// Two-bank ping-pong buffer of signed samples held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Takes one request per clock: busy stays low, so a request is taken at every
// edge where start is high. Each request yields one result, presented with
// done for exactly one cycle, in the cycle after the request is taken; the
// receiver cannot stall it. Popped data comes from the registered bank RAM read.
// The RAM sees at most one access per cycle (a push writes, a pop reads), and
// a push always targets the write bank while a pop targets the read bank, so
// no forwarding is needed. The RAM holds no reset state; only entries that were
// pushed are ever read back. bank_limit is written through the APB port at
// address 0; the user must do so only while the unit is idle, as the unit itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module ping_pong_sample_buffer_unit #(
  parameter int unsigned BANK_DEPTH   = ppsb_pkg::BANK_DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = ppsb_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request side
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        cmd,
  input  wire logic signed [ppsb_pkg::DATA_W-1:0] push_data,
  // result side
  output logic                                   done,
  output logic                                   push_accepted,
  output logic                                   pop_valid,
  output logic signed [ppsb_pkg::DATA_W-1:0]     pop_data,
  output logic                                   did_swap,
  output logic                                   read_bank_empty,
  // APB register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ppsb_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [ppsb_pkg::APB_W-1:0]        pwdata,
  output logic [ppsb_pkg::APB_W-1:0]             prdata,
  output logic                                   pready
);

  import ppsb_pkg::*;

  localparam int unsigned CW  = $clog2(BANK_DEPTH + 1);     // count width
  localparam int unsigned IW  = $clog2(BANK_DEPTH);         // in-bank index
  localparam int unsigned AW  = $clog2(2 * BANK_DEPTH);     // RAM address
  localparam int unsigned LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(BANK_DEPTH);

  // Control state
  logic              read_bank_select;
  logic [CW-1:0]     write_count;
  logic [CW-1:0]     read_head;
  logic [CW-1:0]     read_count;
  logic [LIMIT_W-1:0] bank_limit;

  // Bank RAM
  logic [SAMPLE_WIDTH-1:0] bank_store [2*BANK_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_data;

  logic          take;
  logic          push_ok;
  logic          pop_hit;
  logic          pop_swap;
  logic [IW-1:0] head_idx;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [SAMPLE_WIDTH-1:0] wr_data;
  logic          cfg_wr;

  assign busy   = 1'b0;
  assign take   = start && !busy;
  assign pready = 1'b1;

  // Request decode
  assign push_ok  = take && (cmd == CMD_PUSH) &&
                    (LW'(write_count) < LW'(bank_limit)) && (write_count < DEPTH_C);
  assign pop_swap = take && (cmd == CMD_POP) && (read_count == '0);
  assign pop_hit  = take && (cmd == CMD_POP) && (read_count != '0);

  // Addresses: bank b occupies [b*DEPTH, b*DEPTH + DEPTH)
  assign head_idx = (read_head < DEPTH_C) ? read_head[IW-1:0] : '0;
  assign wr_addr  = read_bank_select ? AW'(write_count[IW-1:0])
                                     : AW'(BANK_DEPTH) + AW'(write_count[IW-1:0]);
  assign rd_addr  = read_bank_select ? AW'(BANK_DEPTH) + AW'(head_idx)
                                     : AW'(head_idx);
  assign wr_data  = SAMPLE_WIDTH'(push_data);

  // RAM write and registered read
  always_ff @(posedge clk) begin
    if (push_ok) begin
      bank_store[wr_addr] <= wr_data;
    end
    if (pop_hit) begin
      rd_data <= bank_store[rd_addr];
    end
  end

  // Bank pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      read_bank_select <= 1'b0;
      write_count      <= '0;
      read_head        <= '0;
      read_count       <= '0;
    end else if (take) begin
      case (cmd)
        CMD_PUSH: begin
          if (push_ok) begin
            write_count <= write_count + CW'(1);
          end
        end
        CMD_POP: begin
          if (read_count == '0) begin
            read_bank_select <= ~read_bank_select;
            read_count       <= write_count;
            read_head        <= '0;
            write_count      <= '0;
          end else begin
            read_head  <= CW'(head_idx) + CW'(1);
            read_count <= read_count - CW'(1);
          end
        end
        CMD_FLUSH: begin
          write_count <= '0;
          read_head   <= '0;
          read_count  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result flags, registered in the cycle after the request
  always_ff @(posedge clk) begin
    if (rst) begin
      done            <= 1'b0;
      push_accepted   <= 1'b0;
      pop_valid       <= 1'b0;
      did_swap        <= 1'b0;
      read_bank_empty <= 1'b1;
    end else begin
      done          <= take;
      push_accepted <= push_ok;
      pop_valid     <= pop_hit;
      did_swap      <= pop_swap;
      if (take) begin
        case (cmd)
          CMD_POP: begin
            read_bank_empty <= (read_count == '0) ? (write_count == '0)
                                                  : (read_count == CW'(1));
          end
          CMD_FLUSH: begin
            read_bank_empty <= 1'b1;
          end
          default: begin
            read_bank_empty <= (read_count == '0);
          end
        endcase
      end
    end
  end

  assign pop_data = pop_valid ? signed'(DATA_W'(rd_data)) : '0;

  // APB register
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BANK_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      bank_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BANK_LIMIT) ? APB_W'(bank_limit) : '0;

`ifndef NO_ASSERTIONS
  // Every taken request produces exactly one result next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> done)
    else $error("result missing after request");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !take |=> !done)
    else $error("result without request");

  // Counts never exceed a bank
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (read_count <= DEPTH_C) && (write_count <= DEPTH_C))
    else $error("bank count overflow");

  // Reported emptiness matches the live read count
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (read_bank_empty == (read_count == '0)))
    else $error("read_bank_empty disagrees with read count");

  // A swap flips the bank roles
  a_swap_flip: assert property (@(posedge clk) disable iff (rst)
    pop_swap |=> (read_bank_select != $past(read_bank_select)) && did_swap)
    else $error("swap did not exchange banks");
`endif

endmodule

`default_nettype wire

### verif/ping_pong_sample_buffer_unit_test.sv
// ----------------------------------------------------------------------------
// ping_pong_sample_buffer_unit_test
// Self-checking bench for the ping-pong sample buffer. A short table of
// directed requests runs first, then phases of weighted random requests under
// several bank limits. Typed rows are checked against their table results, all
// others against a shadow copy of the two banks, their counts and the limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ping_pong_sample_buffer_unit_test;
  import ppsb_pkg::*;

  localparam int unsigned DEPTH = BANK_DEPTH_DEF;
  localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * int'(REG_BANK_LIMIT));
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic              acc;
    logic              vld;
    logic [DATA_W-1:0] data;
    logic              swp;
    logic              rbe;
  } buf_result_t;

  typedef struct {
    cmd_t              op;
    logic [DATA_W-1:0] sample;
    bit                typed;
    buf_result_t       res;
  } stim_row_t;

  // DUT ports
  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                cmd = CMD_NOP;
  logic signed [DATA_W-1:0]  push_data = '0;
  logic                      done;
  logic                      push_accepted;
  logic                      pop_valid;
  logic signed [DATA_W-1:0]  pop_data;
  logic                      did_swap;
  logic                      read_bank_empty;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [APB_W-1:0]          pwdata = '0;
  logic [APB_W-1:0]          prdata;
  logic                      pready;

  // Shadow state of the buffer
  logic [DATA_W-1:0] shadow_bank [2*DEPTH];
  bit                shadow_sel = 1'b0;
  int unsigned       shadow_wr_count = 0;
  int unsigned       shadow_head = 0;
  int unsigned       shadow_rd_count = 0;
  int unsigned       shadow_limit = LIMIT_RESET;

  buf_result_t pending_results [$];
  stim_row_t   directed_rows [$];
  int          mismatch_count = 0;

  // Random phases: limit, length, command weights (percent), idling on/off
  int unsigned ph_limit [NUM_PHASES] = '{0, 8, 2, 1, 2047, 1024, 5, 1023};
  int          ph_len   [NUM_PHASES] = '{50, 120, 80, 60, 300, 200, 100, 65};
  int          ph_push  [NUM_PHASES] = '{55, 60, 55, 50, 100, 4, 50, 55};
  int          ph_pop   [NUM_PHASES] = '{35, 33, 40, 45, 0, 95, 40, 38};
  int          ph_flush [NUM_PHASES] = '{5, 3, 2, 3, 0, 0, 5, 2};
  bit          ph_idle  [NUM_PHASES] = '{1, 1, 1, 0, 0, 1, 1, 1};

  ping_pong_sample_buffer_unit i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the DUT hangs
  initial begin
    #3_000_000;
    $display("ping_pong_sample_buffer_unit: mismatch");
    $finish;
  end

  // Shadow buffer: applies one request, returns the expected result
  function automatic buf_result_t apply_request(cmd_t op, logic [DATA_W-1:0] sample);
    buf_result_t r;
    int unsigned cap;
    int unsigned h;
    r = '0;
    cap = (shadow_limit > DEPTH) ? DEPTH : shadow_limit;
    case (op)
      CMD_PUSH: begin
        if (shadow_wr_count < cap) begin
          shadow_bank[int'(!shadow_sel) * DEPTH + shadow_wr_count] = sample;
          shadow_wr_count++;
          r.acc = 1'b1;
        end
      end
      CMD_POP: begin
        if (shadow_rd_count == 0) begin
          // empty read bank: banks trade roles, no data
          shadow_sel = !shadow_sel;
          shadow_rd_count = shadow_wr_count;
          shadow_head = 0;
          shadow_wr_count = 0;
          r.swp = 1'b1;
        end else begin
          h = (shadow_head < DEPTH) ? shadow_head : 0;
          r.data = shadow_bank[int'(shadow_sel) * DEPTH + h];
          r.vld = 1'b1;
          shadow_head = h + 1;
          shadow_rd_count--;
        end
      end
      CMD_FLUSH: begin
        shadow_wr_count = 0;
        shadow_head = 0;
        shadow_rd_count = 0;
      end
      default: ;
    endcase
    r.rbe = (shadow_rd_count == 0);
    return r;
  endfunction

  function automatic void add_row(cmd_t op, logic [DATA_W-1:0] sample, bit typed,
                                  bit acc, bit vld, logic [DATA_W-1:0] data,
                                  bit swp, bit rbe);
    stim_row_t row;
    row.op = op;
    row.sample = sample;
    row.typed = typed;
    row.res = '{acc: acc, vld: vld, data: data, swp: swp, rbe: rbe};
    directed_rows.push_back(row);
  endfunction

  function automatic int draw_gap(bit idle);
    if (!idle || $urandom_range(3) == 0) return 0;
    return $urandom_range(11);
  endfunction

  // Present one request, wait for it to be taken, queue its expected result
  task automatic issue_request(input cmd_t op, input logic [DATA_W-1:0] sample,
                               input int gap, input bit typed,
                               input buf_result_t typed_res);
    buf_result_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    cmd       <= op;
    push_data <= sample;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_request(op, sample);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Hold requests off until every outstanding result has come back
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // APB write of bank_limit, then read it back
  task automatic program_limit(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= APB_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    shadow_limit = value & 32'h7FF;
    // read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== APB_W'(shadow_limit))
      note_mismatch($sformatf("bank_limit readback exp %0d got %0d", shadow_limit, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result checker: one strobe per request, in order
  buf_result_t got_res;
  buf_result_t exp_res;
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      got_res = '{acc: push_accepted, vld: pop_valid, data: pop_data,
                  swp: did_swap, rbe: read_bank_empty};
      if (pending_results.size() == 0) begin
        note_mismatch("result strobe with no request outstanding");
      end else begin
        exp_res = pending_results.pop_front();
        if (got_res !== exp_res)
          note_mismatch($sformatf(
            "exp acc=%b vld=%b data=%h swp=%b rbe=%b got acc=%b vld=%b data=%h swp=%b rbe=%b",
            exp_res.acc, exp_res.vld, exp_res.data, exp_res.swp, exp_res.rbe,
            got_res.acc, got_res.vld, got_res.data, got_res.swp, got_res.rbe));
      end
    end
  end

  // Stimulus
  initial begin
    cmd_t        op;
    logic [15:0] sample;
    int          r;
    stim_row_t   row;

    // Directed table, limit at its reset value
    //      op         data     typed acc vld data     swp rbe
    add_row(CMD_POP,   16'h0000, 1, 0, 0, 16'h0000, 1, 1); // swap on empty
    add_row(CMD_PUSH,  16'h7FFF, 1, 1, 0, 16'h0000, 0, 1);
    add_row(CMD_PUSH,  16'h8000, 1, 1, 0, 16'h0000, 0, 1);
    add_row(CMD_PUSH,  16'hFFFF, 1, 1, 0, 16'h0000, 0, 1);
    add_row(CMD_PUSH,  16'h0000, 1, 1, 0, 16'h0000, 0, 1);
    add_row(CMD_PUSH,  16'h5555, 1, 1, 0, 16'h0000, 0, 1);
    add_row(CMD_PUSH,  16'hAAAA, 1, 1, 0, 16'h0000, 0, 1);
    add_row(CMD_NOP,   16'h1234, 1, 0, 0, 16'h0000, 0, 1);
    add_row(CMD_POP,   16'hFFFF, 1, 0, 0, 16'h0000, 1, 0); // swap with six queued
    add_row(CMD_POP,   16'h0000, 1, 0, 1, 16'h7FFF, 0, 0);
    add_row(CMD_POP,   16'h0000, 1, 0, 1, 16'h8000, 0, 0);
    add_row(CMD_PUSH,  16'h0001, 1, 1, 0, 16'h0000, 0, 0);
    add_row(CMD_NOP,   16'hEDCB, 1, 0, 0, 16'h0000, 0, 0);
    add_row(CMD_POP,   16'h0000, 1, 0, 1, 16'hFFFF, 0, 0);
    add_row(CMD_POP,   16'h0000, 1, 0, 1, 16'h0000, 0, 0);
    add_row(CMD_POP,   16'h0000, 1, 0, 1, 16'h5555, 0, 0);
    add_row(CMD_POP,   16'h0000, 1, 0, 1, 16'hAAAA, 0, 1); // read bank drained
    add_row(CMD_POP,   16'h0000, 1, 0, 0, 16'h0000, 1, 0);
    add_row(CMD_FLUSH, 16'h7FFF, 1, 0, 0, 16'h0000, 0, 1);
    add_row(CMD_POP,   16'h0000, 1, 0, 0, 16'h0000, 1, 1); // swap after flush
    add_row(CMD_PUSH,  16'h1357, 0, 0, 0, 16'h0000, 0, 0);
    add_row(CMD_PUSH,  16'hECA8, 0, 0, 0, 16'h0000, 0, 0);
    add_row(CMD_POP,   16'h0000, 0, 0, 0, 16'h0000, 0, 0);
    add_row(CMD_FLUSH, 16'h0000, 0, 0, 0, 16'h0000, 0, 0); // flush with data queued
    add_row(CMD_POP,   16'h0000, 0, 0, 0, 16'h0000, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      issue_request(row.op, row.sample, draw_gap(1'b1), row.typed, row.res);
    end

    // Random phases, each under its own limit
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      repeat (2) @(posedge clk);
      program_limit(ph_limit[p]);
      for (int n = 0; n < ph_len[p]; n++) begin
        r = $urandom_range(99);
        if (r < ph_push[p]) op = CMD_PUSH;
        else if (r < ph_push[p] + ph_pop[p]) op = CMD_POP;
        else if (r < ph_push[p] + ph_pop[p] + ph_flush[p]) op = CMD_FLUSH;
        else op = CMD_NOP;
        case ($urandom_range(7))
          0: sample = 16'h7FFF;
          1: sample = 16'h8000;
          2: sample = 16'hFFFF;
          3: sample = 16'h0000;
          default: sample = 16'($urandom());
        endcase
        // occasionally let the pipe run dry mid-phase
        if ($urandom_range(49) == 0) wait_idle();
        issue_request(op, sample, draw_gap(ph_idle[p]), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ping_pong_sample_buffer_unit: match");
    end else begin
      $display("ping_pong_sample_buffer_unit: mismatch");
    end
    $finish;
  end

endmodule

### ping_pong_sample_buffer_unit.f
rtl/ppsb_pkg.sv
rtl/ping_pong_sample_buffer_unit.sv
verif/ping_pong_sample_buffer_unit_test.sv
